// ===== hw/rtl/cbf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared sizes, command and status codes and pointer helpers for the
// circular byte fifo.
// ----------------------------------------------------------------------------
package cbf_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 8;
	localparam int MAX_BLOCK  = 64;

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int LEN_W  = 9;
	localparam int CNT_W  = 9;
	localparam int BLK_W  = $clog2(MAX_BLOCK + 1);
	localparam int STEP_W = $clog2(CNT_W + 1);

	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(DEPTH);

	typedef enum logic [2:0] {
		CMD_PUSH  = 3'd0,
		CMD_POP   = 3'd1,
		CMD_PEEK  = 3'd2,
		CMD_BLOCK = 3'd3,
		CMD_SKIP  = 3'd4,
		CMD_RESET = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_ROOM  = 2'd1,
		STAT_NO_DATA  = 2'd2,
		STAT_TOO_LONG = 2'd3
	} status_t;

	// remainder unit request and response
	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [PTR_W-1:0] rem;
	} mod_rsp_t;

	function automatic logic [LEN_W-1:0] free_space(logic [PTR_W-1:0] wp,
			logic [PTR_W-1:0] rp, logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] res;
		if (wp == rp) begin
			res = len;
		end else if (wp > rp) begin
			res = len - {1'b0, wp} + {1'b0, rp};
		end else begin
			res = {1'b0, rp} - {1'b0, wp};
		end
		return res;
	endfunction

	function automatic logic [PTR_W-1:0] advance1(logic [PTR_W-1:0] p,
			logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] nxt;
		nxt = {1'b0, p} + LEN_W'(1);
		if (nxt == len) begin
			nxt = '0;
		end
		return nxt[PTR_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] res;
		if (v < LEN_MIN) begin
			res = LEN_MIN;
		end else if (v > LEN_RESET) begin
			res = LEN_RESET;
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/circular_byte_fifo.sv =====
// ----------------------------------------------------------------------------
// circular_byte_fifo
// Ring-buffer fifo over a 256-entry byte RAM with a configurable ring length.
//
//   channel   handshake            payload
//   request   start & !busy        cmd, data_in, count
//   result    result_valid         status, data_out, last, free_count,
//                                  fill_count
//   config    cfg_we               cfg_wdata (ring length)
//
// Push, pop, peek, reset and unknown commands may be issued back to back;
// the result follows in the cycle after the request.
// A block pop of n elements holds busy after its first element until its
// last, and streams one element per cycle from the RAM read port. A skip
// holds busy until the bit-serial remainder unit reports done.
// Results cannot be stalled.
// Reset clears both pointers and sets the ring length to 256; RAM contents
// are undefined until written.
// ----------------------------------------------------------------------------
module circular_byte_fifo
	import cbf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            cmd,
	input  logic [DATA_WIDTH-1:0] data_in,
	input  logic [CNT_W-1:0]      count,
	input  logic                  cfg_we,
	input  logic [LEN_W-1:0]      cfg_wdata,
	output logic                  result_valid,
	output logic [1:0]            status,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic                  last,
	output logic [LEN_W-1:0]      free_count,
	output logic [LEN_W-1:0]      fill_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BLOCK,
		ST_SKIP
	} state_t;

	state_t            state_q, state_n;
	logic [PTR_W-1:0]  wp_q, wp_n;
	logic [PTR_W-1:0]  rp_q, rp_n;
	logic [LEN_W-1:0]  len_q;
	logic [BLK_W-1:0]  left_q, left_n;

	logic              valid_s1;
	logic              rd_s1;
	status_t           status_s1;
	logic              last_s1;
	logic [LEN_W-1:0]  free_s1;
	logic [LEN_W-1:0]  fill_s1;

	logic              emit, rd, last_n;
	status_t           status_n;
	logic [LEN_W-1:0]  free_cur, fill_cur, free_n;
	logic [LEN_W-1:0]  skip_sum;
	logic              ram_we, ram_re;
	logic [DATA_WIDTH-1:0] ram_rdata;
	mod_req_t          mod_req;
	mod_rsp_t          mod_rsp;

	cbf_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (data_in),
		.re    (ram_re),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	cbf_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	assign busy     = (state_q != ST_IDLE);
	assign free_cur = free_space(wp_q, rp_q, len_q);
	assign fill_cur = len_q - free_cur;
	assign skip_sum = {1'b0, rp_q} + {1'b0, mod_rsp.rem};

	always_comb begin
		state_n  = state_q;
		wp_n     = wp_q;
		rp_n     = rp_q;
		left_n   = left_q;
		emit     = 1'b0;
		rd       = 1'b0;
		last_n   = 1'b1;
		status_n = STAT_OK;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		mod_req.valid    = 1'b0;
		mod_req.dividend = count;
		mod_req.divisor  = len_q;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					emit = 1'b1;
					case (cmd_t'(cmd))
						CMD_PUSH: begin
							if (free_cur <= LEN_W'(1)) begin
								status_n = STAT_NO_ROOM;
							end else begin
								ram_we = 1'b1;
								wp_n   = advance1(wp_q, len_q);
							end
						end
						CMD_POP, CMD_PEEK: begin
							if (fill_cur == '0) begin
								status_n = STAT_NO_DATA;
							end else begin
								ram_re = 1'b1;
								rd     = 1'b1;
								if (cmd_t'(cmd) == CMD_POP) begin
									rp_n = advance1(rp_q, len_q);
								end
							end
						end
						CMD_BLOCK: begin
							if (count > CNT_W'(MAX_BLOCK)) begin
								status_n = STAT_TOO_LONG;
							end else if (fill_cur < count) begin
								status_n = STAT_NO_DATA;
							end else if (count != '0) begin
								ram_re = 1'b1;
								rd     = 1'b1;
								rp_n   = advance1(rp_q, len_q);
								last_n = (count == CNT_W'(1));
								left_n = count[BLK_W-1:0] - BLK_W'(1);
								if (count != CNT_W'(1)) begin
									state_n = ST_BLOCK;
								end
							end
						end
						CMD_SKIP: begin
							emit          = 1'b0;
							mod_req.valid = 1'b1;
							state_n       = ST_SKIP;
						end
						CMD_RESET: begin
							wp_n = '0;
							rp_n = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_BLOCK: begin
				emit   = 1'b1;
				ram_re = 1'b1;
				rd     = 1'b1;
				rp_n   = advance1(rp_q, len_q);
				last_n = (left_q == BLK_W'(1));
				left_n = left_q - BLK_W'(1);
				if (left_q == BLK_W'(1)) begin
					state_n = ST_IDLE;
				end
			end
			ST_SKIP: begin
				if (mod_rsp.done) begin
					emit    = 1'b1;
					rp_n    = (skip_sum >= len_q) ? PTR_W'(skip_sum - len_q)
						: skip_sum[PTR_W-1:0];
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		// counts reflect the pointers after this request
		free_n = free_space(wp_n, rp_n, len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wp_q     <= '0;
			rp_q     <= '0;
			len_q    <= LEN_RESET;
			left_q   <= '0;
			valid_s1 <= 1'b0;
			rd_s1    <= 1'b0;
		end else begin
			state_q  <= state_n;
			left_q   <= left_n;
			valid_s1 <= emit;
			rd_s1    <= rd;
			if (cfg_we) begin
				len_q <= clamp_len(cfg_wdata);
				wp_q  <= '0;
				rp_q  <= '0;
			end else begin
				wp_q <= wp_n;
				rp_q <= rp_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_s1 <= status_n;
			last_s1   <= last_n;
			free_s1   <= free_n;
			fill_s1   <= len_q - free_n;
		end
	end

	assign result_valid = valid_s1;
	assign status       = status_s1;
	assign data_out     = rd_s1 ? ram_rdata : '0;
	assign last         = last_s1;
	assign free_count   = free_s1;
	assign fill_count   = fill_s1;

endmodule

// ===== hw/rtl/cbf_ram.sv =====
// ----------------------------------------------------------------------------
// cbf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/cbf_mod.sv =====
// ----------------------------------------------------------------------------
// cbf_mod
// Bit-serial remainder unit: one dividend bit per cycle, most significant
// first; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module cbf_mod
	import cbf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [PTR_W-1:0]  rem_q;
	logic [CNT_W-1:0]  shf_q;
	logic [LEN_W-1:0]  div_q;
	logic [LEN_W-1:0]  trial;
	logic [LEN_W-1:0]  nxt;

	// shift in the next dividend bit, subtract once if it fits
	assign trial = {rem_q, shf_q[CNT_W-1]};
	assign nxt   = (trial >= div_q) ? trial - div_q : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.valid) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(CNT_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			rem_q <= '0;
			shf_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= nxt[PTR_W-1:0];
			shf_q <= {shf_q[CNT_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== test/cbf_checker.sv =====
// ----------------------------------------------------------------------------
// cbf_checker
// Watches the request, config and result channels of the circular byte fifo.
// Keeps its own copy of the ring, pointers and length, works out the replies
// each accepted request should produce and compares every result strobe with
// the oldest pending reply, field by field.
// ----------------------------------------------------------------------------
module cbf_checker
	import cbf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [2:0]            cmd,
	input  logic [DATA_WIDTH-1:0] data_in,
	input  logic [CNT_W-1:0]      count,
	input  logic                  cfg_we,
	input  logic [LEN_W-1:0]      cfg_wdata,
	input  logic                  result_valid,
	input  logic [1:0]            status,
	input  logic [DATA_WIDTH-1:0] data_out,
	input  logic                  last,
	input  logic [LEN_W-1:0]      free_count,
	input  logic [LEN_W-1:0]      fill_count,
	output int                    errors,
	output int                    outstanding
);

	typedef struct packed {
		status_t               st;
		logic [DATA_WIDTH-1:0] elem;
		logic                  is_last;
		logic [LEN_W-1:0]      free_n;
		logic [LEN_W-1:0]      fill_n;
	} reply_t;

	reply_t                replies[$];
	logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
	int unsigned           wr_ptr;
	int unsigned           rd_ptr;
	int unsigned           ring_len;
	int                    fail_count = 0;

	assign errors = fail_count;

	function automatic int unsigned ring_free();
		int unsigned res;
		if (wr_ptr == rd_ptr) begin
			res = ring_len;
		end else if (wr_ptr > rd_ptr) begin
			res = ring_len - wr_ptr + rd_ptr;
		end else begin
			res = rd_ptr - wr_ptr;
		end
		return res;
	endfunction

	// counts are taken after the state change that this reply reports
	function automatic void post_reply(status_t st, logic [DATA_WIDTH-1:0] elem,
			logic is_last);
		reply_t      r;
		int unsigned fr;
		fr = ring_free();
		r.st      = st;
		r.elem    = elem;
		r.is_last = is_last;
		r.free_n  = LEN_W'(fr);
		r.fill_n  = LEN_W'(ring_len - fr);
		replies.push_back(r);
	endfunction

	function automatic void apply_request(logic [2:0] c, logic [DATA_WIDTH-1:0] d,
			logic [CNT_W-1:0] n);
		int unsigned           held;
		logic [DATA_WIDTH-1:0] v;
		held = ring_len - ring_free();
		case (c)
			CMD_PUSH: begin
				if (ring_free() <= 1) begin
					post_reply(STAT_NO_ROOM, '0, 1'b1);
				end else begin
					ring_mem[wr_ptr] = d;
					wr_ptr = (wr_ptr + 1) % ring_len;
					post_reply(STAT_OK, '0, 1'b1);
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (held == 0) begin
					post_reply(STAT_NO_DATA, '0, 1'b1);
				end else begin
					v = ring_mem[rd_ptr];
					if (c == CMD_POP) begin
						rd_ptr = (rd_ptr + 1) % ring_len;
					end
					post_reply(STAT_OK, v, 1'b1);
				end
			end
			CMD_BLOCK: begin
				if (n > MAX_BLOCK) begin
					post_reply(STAT_TOO_LONG, '0, 1'b1);
				end else if (held < n) begin
					post_reply(STAT_NO_DATA, '0, 1'b1);
				end else if (n == 0) begin
					post_reply(STAT_OK, '0, 1'b1);
				end else begin
					for (int i = 0; i < int'(n); i++) begin
						v = ring_mem[rd_ptr];
						rd_ptr = (rd_ptr + 1) % ring_len;
						post_reply(STAT_OK, v, i == int'(n) - 1);
					end
				end
			end
			CMD_SKIP: begin
				// no fill check: the read pointer may pass the write pointer
				rd_ptr = (rd_ptr + n % ring_len) % ring_len;
				post_reply(STAT_OK, '0, 1'b1);
			end
			CMD_RESET: begin
				wr_ptr = 0;
				rd_ptr = 0;
				post_reply(STAT_OK, '0, 1'b1);
			end
			default: begin
				post_reply(STAT_OK, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic void check_reply();
		reply_t want;
		if (replies.size() == 0) begin
			if (fail_count < 10) begin
				$display("unexpected result: status %0d data %02h last %0d free %0d fill %0d",
					status, data_out, last, free_count, fill_count);
			end
			fail_count++;
		end else begin
			want = replies.pop_front();
			if (status !== want.st || data_out !== want.elem || last !== want.is_last ||
					free_count !== want.free_n || fill_count !== want.fill_n) begin
				if (fail_count < 10) begin
					$display("result mismatch (expected/actual): status %0d/%0d data %02h/%02h",
						want.st, status, want.elem, data_out);
					$display("  last %0d/%0d free %0d/%0d fill %0d/%0d",
						want.is_last, last, want.free_n, free_count, want.fill_n, fill_count);
				end
				fail_count++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr = 0;
			rd_ptr = 0;
			ring_len = DEPTH;
			replies.delete();
			outstanding <= 0;
		end else begin
			if (result_valid) begin
				check_reply();
			end
			if (cfg_we) begin
				if (cfg_wdata < 2) begin
					ring_len = 2;
				end else if (cfg_wdata > DEPTH) begin
					ring_len = DEPTH;
				end else begin
					ring_len = cfg_wdata;
				end
				wr_ptr = 0;
				rd_ptr = 0;
			end
			if (start && !busy) begin
				apply_request(cmd, data_in, count);
			end
			outstanding <= replies.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for the circular byte fifo. A short directed run covers empty,
// full, too-long and zero-length block pops, skips, pointer reset and unused
// command codes; then random traffic runs over several ring lengths with push
// bursts followed by block pops. A shadow of the pointers keeps reads off
// slots that were never written. Results are checked by cbf_checker.
// ----------------------------------------------------------------------------
module tb
	import cbf_pkg::*;
;

	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int         ITEMS        = 380;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         SETTLE       = CNT_W + 6;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	logic [2:0]            cmd       = '0;
	logic [DATA_WIDTH-1:0] data_in   = '0;
	logic [CNT_W-1:0]      count     = '0;
	logic                  cfg_we    = 1'b0;
	logic [LEN_W-1:0]      cfg_wdata = '0;
	logic                  result_valid;
	logic [1:0]            status;
	logic [DATA_WIDTH-1:0] data_out;
	logic                  last;
	logic [LEN_W-1:0]      free_count;
	logic [LEN_W-1:0]      fill_count;
	int                    errors;
	int                    outstanding;

	// shadow pointers, used only to steer the stimulus
	int unsigned wp_s;
	int unsigned rp_s;
	int unsigned len_s;
	bit          written [DEPTH];
	int          sent      = 0;
	int          idle_pct  = 0;
	int unsigned cycles    = 0;

	circular_byte_fifo u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.data_in      (data_in),
		.count        (count),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.status       (status),
		.data_out     (data_out),
		.last         (last),
		.free_count   (free_count),
		.fill_count   (fill_count)
	);

	cbf_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.data_in      (data_in),
		.count        (count),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.status       (status),
		.data_out     (data_out),
		.last         (last),
		.free_count   (free_count),
		.fill_count   (fill_count),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("circular_byte_fifo regression: fail");
			$finish;
		end
	end

	function automatic int unsigned shadow_free();
		int unsigned res;
		if (wp_s == rp_s) begin
			res = len_s;
		end else if (wp_s > rp_s) begin
			res = len_s - wp_s + rp_s;
		end else begin
			res = rp_s - wp_s;
		end
		return res;
	endfunction

	function automatic bit slots_written(int unsigned n);
		bit ok;
		ok = 1'b1;
		for (int unsigned i = 0; i < n; i++) begin
			if (!written[(rp_s + i) % len_s]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	task automatic issue(logic [2:0] c, logic [DATA_WIDTH-1:0] d, logic [CNT_W-1:0] n);
		int unsigned fr;
		int unsigned held;
		fr = shadow_free();
		held = len_s - fr;
		// a read of a never-written slot would be meaningless, push instead
		if (((c == CMD_POP || c == CMD_PEEK) && held > 0 && !slots_written(1)) ||
				(c == CMD_BLOCK && n >= 1 && n <= MAX_BLOCK && held >= n &&
				!slots_written(n))) begin
			c = CMD_PUSH;
		end
		if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < idle_pct);
		end
		start   <= 1'b1;
		cmd     <= c;
		data_in <= d;
		count   <= n;
		do @(posedge clk); while (busy);
		if (c <= CMD_RESET) begin
			sent++;
		end
		case (c)
			CMD_PUSH: begin
				if (fr > 1) begin
					written[wp_s] = 1'b1;
					wp_s = (wp_s + 1) % len_s;
				end
			end
			CMD_POP: begin
				if (held > 0) begin
					rp_s = (rp_s + 1) % len_s;
				end
			end
			CMD_BLOCK: begin
				if (n <= MAX_BLOCK && held >= n) begin
					rp_s = (rp_s + n) % len_s;
				end
			end
			CMD_SKIP: begin
				rp_s = (rp_s + n % len_s) % len_s;
			end
			CMD_RESET: begin
				wp_s = 0;
				rp_s = 0;
			end
			default: ;
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_length(logic [LEN_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (v < 2) begin
			len_s = 2;
		end else if (v > DEPTH) begin
			len_s = DEPTH;
		end else begin
			len_s = v;
		end
		wp_s = 0;
		rp_s = 0;
	endtask

	task automatic random_request(int push_pct);
		int unsigned held;
		int unsigned lim;
		int          r;
		logic [DATA_WIDTH-1:0] d;
		held = len_s - shadow_free();
		lim = (held < MAX_BLOCK) ? held : MAX_BLOCK;
		d = ($urandom_range(7, 0) == 0) ? {DATA_WIDTH{$urandom_range(1, 0) == 1}} :
			DATA_WIDTH'($urandom);
		if ($urandom_range(99, 0) < push_pct) begin
			issue(CMD_PUSH, d, CNT_W'($urandom_range(511, 0)));
		end else begin
			r = $urandom_range(99, 0);
			if (r < 35) begin
				issue(CMD_POP, d, CNT_W'($urandom_range(511, 0)));
			end else if (r < 50) begin
				issue(CMD_PEEK, d, CNT_W'($urandom_range(511, 0)));
			end else if (r < 75) begin
				if ($urandom_range(4, 0) != 0) begin
					issue(CMD_BLOCK, d, CNT_W'($urandom_range(lim, 0)));
				end else begin
					issue(CMD_BLOCK, d, CNT_W'($urandom_range(511, 0)));
				end
			end else if (r < 87) begin
				if ($urandom_range(3, 0) != 0) begin
					issue(CMD_SKIP, d, CNT_W'($urandom_range(held, 0)));
				end else begin
					issue(CMD_SKIP, d, CNT_W'($urandom_range(511, 0)));
				end
			end else if (r < 94) begin
				issue(CMD_RESET, d, CNT_W'($urandom_range(511, 0)));
			end else begin
				issue(($urandom_range(1, 0) == 1) ? CMD_SPARE_HI : CMD_SPARE_LO, d,
					CNT_W'($urandom_range(511, 0)));
			end
		end
	endtask

	task automatic random_phase(int n_items, int push_pct);
		int stop_at;
		int k;
		stop_at = sent + n_items;
		while (sent < stop_at) begin
			// sender idles 37 in 100, then 81 in 100, then not at all
			idle_pct = (sent < ITEMS / 3) ? 37 : (sent < 2 * ITEMS / 3) ? 81 : 0;
			if ($urandom_range(9, 0) == 0) begin
				// a run of pushes read back by one block pop
				k = ($urandom_range(3, 0) == 0) ? $urandom_range(MAX_BLOCK, 1) :
					$urandom_range(12, 1);
				for (int i = 0; i < k; i++) begin
					issue(CMD_PUSH, DATA_WIDTH'($urandom), CNT_W'($urandom_range(511, 0)));
				end
				issue(CMD_BLOCK, DATA_WIDTH'($urandom), CNT_W'(k));
			end else begin
				random_request(push_pct);
			end
		end
	endtask

	initial begin
		wp_s = 0;
		rp_s = 0;
		len_s = DEPTH;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ring, count limits, element extremes, skips and unused codes
		issue(CMD_POP, 8'h00, 9'd0);
		issue(CMD_PEEK, 8'hFF, 9'h1FF);
		issue(CMD_BLOCK, 8'h00, 9'd0);
		issue(CMD_BLOCK, 8'h00, CNT_W'(MAX_BLOCK + 1));
		issue(CMD_BLOCK, 8'h00, 9'h1FF);
		issue(CMD_BLOCK, 8'h00, CNT_W'(MAX_BLOCK));
		issue(CMD_BLOCK, 8'h00, 9'd3);
		issue(CMD_PUSH, 8'h00, 9'd0);
		issue(CMD_PUSH, 8'hFF, 9'h1FF);
		issue(CMD_PUSH, 8'h5A, 9'd0);
		issue(CMD_PEEK, 8'h00, 9'd0);
		issue(CMD_BLOCK, 8'h00, 9'd3);
		issue(CMD_PUSH, 8'hA5, 9'd0);
		issue(CMD_PUSH, 8'h3C, 9'd0);
		issue(CMD_POP, 8'h00, 9'd0);
		issue(CMD_SKIP, 8'h00, 9'd0);
		issue(CMD_SKIP, 8'h00, 9'd1);
		issue(CMD_SPARE_LO, 8'hFF, 9'h1FF);
		issue(CMD_SPARE_HI, 8'h00, 9'd0);
		issue(CMD_RESET, 8'h00, 9'd0);

		// length below the minimum: full ring refuses the push
		set_length(9'd0);
		issue(CMD_PUSH, 8'h11, 9'd0);
		issue(CMD_PUSH, 8'h22, 9'd0);
		issue(CMD_PEEK, 8'h00, 9'd0);
		issue(CMD_POP, 8'h00, 9'd0);
		issue(CMD_POP, 8'h00, 9'd0);
		issue(CMD_PUSH, 8'h7E, 9'd0);
		issue(CMD_SKIP, 8'h00, 9'h1FF);

		sent = 0;
		set_length(9'h1FF);
		random_phase(ITEMS / 9, 65);
		set_length(9'd3);
		random_phase(ITEMS / 9, 35);
		set_length(9'd2);
		random_phase(ITEMS / 9, 65);
		set_length(9'd17);
		random_phase(ITEMS / 9, 65);
		set_length(9'd256);
		random_phase(ITEMS / 9, 35);
		set_length(9'd1);
		random_phase(ITEMS / 9, 35);
		set_length(9'd300);
		random_phase(ITEMS / 9, 65);
		set_length(LEN_W'($urandom_range(200, 4)));
		random_phase(ITEMS / 9, 65);
		set_length(9'd64);
		random_phase(ITEMS / 9, 35);

		drain();
		if (errors == 0) begin
			$display("circular_byte_fifo regression: pass");
		end else begin
			$display("circular_byte_fifo regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cbf_pkg.sv
hw/rtl/cbf_ram.sv
hw/rtl/cbf_mod.sv
hw/rtl/circular_byte_fifo.sv
test/cbf_checker.sv
test/tb.sv
